[src/salc_pkg.sv]
// Shared types and fixed geometry of the LRU cache tag store.
package salc_pkg;

    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 32;
    localparam int TOTAL_LINES = 32;
    localparam int WAYS        = 4;
    localparam int SETS        = (TOTAL_LINES / WAYS > 0) ? (TOTAL_LINES / WAYS) : 1;
    localparam int SET_W       = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int TAG_W       = ADDR_W - $clog2(SETS);
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W      = WAY_W;
    localparam int OUT_WAY_W   = 2;

    typedef logic [TAG_W-1:0]               t_tag;
    typedef logic [WAY_W-1:0]               t_way;
    typedef logic [RANK_W-1:0]              t_rank;
    typedef logic [SET_W-1:0]               t_set;
    typedef logic [WAYS-1:0][TAG_W-1:0]     t_tag_row;
    typedef logic [WAYS-1:0][RANK_W-1:0]    t_rank_row;

    // One memory row holds a whole set
    typedef struct packed {
        t_tag_row  tags;
        t_rank_row ranks;
    } t_row;

    typedef struct packed {
        logic hit;
        t_way way;
    } t_lookup;

endpackage

[src/set_assoc_lru_cache_tag_store.sv]
// Top level of the 4-way set-associative tag store with true LRU replacement.
// Accepting start enters S_LOOK; o_valid and the result are registered as S_LOOK ends.
// A new start is not accepted while busy, which is high for the cycle in which the
//   set row read from the single-port row memory is compared and written back.
// Reset (synchronous, active low) clears valid bits and counters; a set with no
//   valid way reads its LRU ranks as the reset order, so no clearing pass is run.
module set_assoc_lru_cache_tag_store
    import salc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ADDR_W-1:0]    i_address,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic [OUT_WAY_W-1:0] o_way,
    output logic [CNT_W-1:0]     o_hit_count,
    output logic [CNT_W-1:0]     o_access_count
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic                       r_state;
    logic                       n_state;
    t_set                       r_set;
    t_tag                       r_tag;
    t_row                       r_rd_row;
    t_row                       r_mem [SETS];
    logic [SETS-1:0][WAYS-1:0]  r_valid;
    logic [CNT_W-1:0]           r_hits;
    logic [CNT_W-1:0]           r_accs;
    logic [CNT_W-1:0]           n_hits;
    logic [CNT_W-1:0]           n_accs;
    logic                       r_out_valid;
    logic                       r_hit;
    t_way                       r_way;

    logic                       w_accept;
    logic                       w_look;
    logic [WAYS-1:0]            w_set_valid;
    t_rank_row                  w_init_ranks;
    t_rank_row                  w_ranks;
    t_rank_row                  w_new_ranks;
    t_lookup                    w_res;
    t_row                       n_row;

    assign w_accept = start && !busy;
    assign w_look   = (r_state == S_LOOK);
    assign busy     = w_look;

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = w_accept ? S_LOOK : S_IDLE;
            S_LOOK:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set <= i_address[SET_W-1:0];
            r_tag <= i_address[ADDR_W-1 -: TAG_W];
        end
    end

    // Row memory: read on accept, write back at the end of the lookup cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_row <= r_mem[i_address[SET_W-1:0]];
        end
        if (w_look) begin
            r_mem[r_set] <= n_row;
        end
    end

    assign w_set_valid = r_valid[r_set];

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_init_ranks[w] = t_rank'(w);
        end
    end

    // A set never touched still holds its reset order
    assign w_ranks = (|w_set_valid) ? r_rd_row.ranks : w_init_ranks;

    salc_lookup u_lookup (
        .i_tag   (r_tag),
        .i_tags  (r_rd_row.tags),
        .i_ranks (w_ranks),
        .i_valid (w_set_valid),
        .o_res   (w_res),
        .o_ranks (w_new_ranks)
    );

    always_comb begin
        n_row.tags  = r_rd_row.tags;
        n_row.ranks = w_new_ranks;
        if (!w_res.hit) begin
            n_row.tags[w_res.way] = r_tag;
        end
    end

    assign n_hits = (w_res.hit && (r_hits != '1)) ? r_hits + CNT_W'(1) : r_hits;
    assign n_accs = (r_accs != '1) ? r_accs + CNT_W'(1) : r_accs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_hits      <= '0;
            r_accs      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_look;
            if (w_look) begin
                r_valid[r_set][w_res.way] <= 1'b1;
                r_hits                    <= n_hits;
                r_accs                    <= n_accs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_look) begin
            r_hit <= w_res.hit;
            r_way <= w_res.way;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hit          = r_hit;
    assign o_way          = OUT_WAY_W'(r_way);
    assign o_hit_count    = r_hits;
    assign o_access_count = r_accs;

    a_strobe_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == S_LOOK))
        else $error("result strobe without a lookup cycle");

    a_one_cycle_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("lookup held busy for more than one cycle");

    a_used_way_mru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_look |-> (w_new_ranks[w_res.way] == '0))
        else $error("used way not made most recently used");

    a_access_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_access_count == $past(o_access_count) + CNT_W'(1))
                     || (o_access_count == '1)))
        else $error("access counter did not advance by one");

    a_hits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_count <= o_access_count)
        else $error("hit count above access count");

endmodule

[src/salc_lookup.sv]
// Tag compare, victim choice and LRU rank update for one set.
module salc_lookup
    import salc_pkg::*;
(
    input  t_tag             i_tag,
    input  t_tag_row         i_tags,
    input  t_rank_row        i_ranks,
    input  logic [WAYS-1:0]  i_valid,
    output t_lookup          o_res,
    output t_rank_row        o_ranks
);

    logic  w_hit;
    logic  w_free;
    t_way  w_hit_way;
    t_way  w_free_way;
    t_way  w_lru_way;
    t_way  w_way;
    t_rank w_old_rank;

    // Descending scan so the lowest-numbered way wins
    always_comb begin
        w_hit      = 1'b0;
        w_free     = 1'b0;
        w_hit_way  = '0;
        w_free_way = '0;
        w_lru_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_valid[w] && (i_tags[w] == i_tag)) begin
                w_hit     = 1'b1;
                w_hit_way = t_way'(w);
            end
            if (!i_valid[w]) begin
                w_free     = 1'b1;
                w_free_way = t_way'(w);
            end
            if (i_ranks[w] == t_rank'(WAYS - 1)) begin
                w_lru_way = t_way'(w);
            end
        end
    end

    assign w_way      = w_hit ? w_hit_way : (w_free ? w_free_way : w_lru_way);
    assign w_old_rank = i_ranks[w_way];
    assign o_res      = '{hit: w_hit, way: w_way};

    // Used way becomes MRU; younger ways age by one
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            if (t_way'(w) == w_way) begin
                o_ranks[w] = '0;
            end else if (i_ranks[w] < w_old_rank) begin
                o_ranks[w] = i_ranks[w] + t_rank'(1);
            end else begin
                o_ranks[w] = i_ranks[w];
            end
        end
    end

endmodule
